// ----- hdl/wdsd_pkg.sv -----
// shared types and constants for the windowed delta spike detector
`timescale 1ns / 1ps

package wdsd_pkg;

   // field widths
   localparam int PRICE_W  = 24;
   localparam int VOLUME_W = 24;
   localparam int MARKER_W = 25;
   localparam int DELTA_W  = 25;
   localparam int DIR_W    = 2;

   // configuration register widths and reset values
   localparam int WIN_W    = 7;
   localparam int MULT_W   = 8;
   localparam int OFFSET_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [WIN_W-1:0]    WIN_RESET    = 7'd20;
   localparam logic [MULT_W-1:0]   MULT_RESET   = 8'd32;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 6'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_MULT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER_OFFSET = 2'd2;

   // ring depth default
   localparam int MAX_WINDOW_DEFAULT = 128;

   // window sum: up to 127 magnitudes of 24 bits
   localparam int SUM_W = VOLUME_W + WIN_W;
   // |delta| * W * 16 and sum * multiplier
   localparam int LHS_W = VOLUME_W + WIN_W + 4;
   localparam int RHS_W = SUM_W + MULT_W;

   // direction codes
   localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
   localparam logic signed [DIR_W-1:0] DIR_BUY  = 2'sb01;
   localparam logic signed [DIR_W-1:0] DIR_SELL = 2'sb11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_FIN
   } wdsd_state_type;

endpackage

// ----- hdl/windowed_delta_spike_detector.sv -----
// windowed delta spike detector top level: ring store, serial window sum, threshold test
`timescale 1ns / 1ps

//  channel  | direction | ports                                   | handshake
//  ---------+-----------+-----------------------------------------+-------------------
//  req      | in        | bar_high, bar_low, ask_volume, bid_vol. | req_valid/req_stall
//  rsp      | out       | fired, direction, marker_price, delta   | rsp_valid/rsp_stall
//  csr      | in        | csr_index, csr_wdata                    | csr_wr_en
//
//  a bar passes ST_SUM, ST_MUL and ST_FIN, with no ring reads while warming up; W is the
//  effective window, walked one ring read per cycle into the shared 31-bit accumulator
//  the next transaction is taken in the idle state, entered once the result is loaded
//  reset (synchronous, active high) clears pointer, bar count, sequencer and valids;
//  registers take reset values, not the ring; only writes since reset are summed
//  a waiting result holds the next transaction in its final step until it is taken

module windowed_delta_spike_detector
   import wdsd_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [PRICE_W-1:0]          req_bar_high,
   input  logic [PRICE_W-1:0]          req_bar_low,
   input  logic [VOLUME_W-1:0]         req_ask_volume,
   input  logic [VOLUME_W-1:0]         req_bid_volume,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_fired,
   output logic signed [DIR_W-1:0]     rsp_direction,
   output logic [MARKER_W-1:0]         rsp_marker_price,
   output logic signed [DELTA_W-1:0]   rsp_net_delta,

   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);

   // configuration registers
   logic [WIN_W-1:0]    win_len_ff;
   logic [MULT_W-1:0]   mult_ff;
   logic [OFFSET_W-1:0] offset_ff;

   // sequencer and control state
   wdsd_state_type state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [WIN_W-1:0] bars_seen_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rd_valid_ff, rd_valid_in;

   // per-transaction working registers
   logic [PRICE_W-1:0]         high_ff, low_ff;
   logic [VOLUME_W-1:0]        mag_ff;
   logic                       selling_ff;
   logic signed [DELTA_W-1:0]  delta_ff;
   logic [WIN_W-1:0]           win_ff;
   logic                       test_en_ff;
   logic [WIN_W-1:0]           issue_cnt_ff;
   logic [PTR_W-1:0]           rd_ptr_ff;
   logic [VOLUME_W-1:0]        rd_data_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [LHS_W-1:0]           lhs_ff;
   logic [RHS_W-1:0]           rhs_ff;

   // ring store, undefined until written
   logic [VOLUME_W-1:0] ring_ff [MAX_WINDOW];

   // output registers
   logic                      fired_ff;
   logic signed [DIR_W-1:0]   dir_ff;
   logic [MARKER_W-1:0]       marker_ff;
   logic signed [DELTA_W-1:0] rsp_delta_ff;

   // sequencer controls
   logic load_item, issue_rd, do_mul, load_rsp;

   // combinational helpers
   logic [WIN_W-1:0]     eff_win;
   logic                 req_selling;
   logic [VOLUME_W-1:0]  req_mag;
   logic                 fire;
   logic [MARKER_W-1:0]  marker_val;
   logic [PTR_W-1:0]     wr_ptr_dec;
   logic [PTR_W-1:0]     rd_ptr_dec;

   // effective window is the register clipped at the ring depth
   assign eff_win = (int'(win_len_ff) < MAX_WINDOW) ? win_len_ff : WIN_W'(MAX_WINDOW);

   assign req_selling = req_bid_volume > req_ask_volume;
   assign req_mag     = req_selling ? (req_bid_volume - req_ask_volume)
                                    : (req_ask_volume - req_bid_volume);

   assign wr_ptr_dec = (wr_ptr_ff == '0) ? PTR_LAST : wr_ptr_ff - PTR_W'(1);
   assign rd_ptr_dec = (rd_ptr_ff == '0) ? PTR_LAST : rd_ptr_ff - PTR_W'(1);

   // threshold test, only once warm and with a nonzero baseline
   assign fire = test_en_ff && (sum_ff != '0) && (RHS_W'(lhs_ff) >= rhs_ff);

   always_comb begin
      if (selling_ff) begin
         marker_val = (low_ff > PRICE_W'(offset_ff))
                    ? MARKER_W'(low_ff - PRICE_W'(offset_ff)) : '0;
      end else begin
         marker_val = MARKER_W'(high_ff) + MARKER_W'(offset_ff);
      end
   end

   // next state and controls
   always_comb begin
      state_in     = state_ff;
      load_item    = 1'b0;
      issue_rd     = 1'b0;
      do_mul       = 1'b0;
      load_rsp     = 1'b0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               load_item = 1'b1;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            // one ring read issued per cycle, its data summed in the cycle after
            issue_rd = test_en_ff && (issue_cnt_ff < win_ff);
            if (!issue_rd && !rd_valid_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            do_mul   = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_valid_in = issue_rd;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         bars_seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         win_len_ff   <= WIN_RESET;
         mult_ff      <= MULT_RESET;
         offset_ff    <= OFFSET_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
         if (do_mul) begin
            // push happens after the window has been read
            wr_ptr_ff    <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
            bars_seen_ff <= (bars_seen_ff < win_ff) ? bars_seen_ff + WIN_W'(1) : win_ff;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WINDOW_LENGTH:  win_len_ff <= csr_wdata[WIN_W-1:0];
               CSR_THRESHOLD_MULT: mult_ff    <= csr_wdata[MULT_W-1:0];
               CSR_MARKER_OFFSET:  offset_ff  <= csr_wdata[OFFSET_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ring store: one write, one registered read
   always_ff @(posedge clock) begin
      if (do_mul) begin
         ring_ff[wr_ptr_ff] <= mag_ff;
      end
      if (issue_rd) begin
         rd_data_ff <= ring_ff[rd_ptr_ff];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (load_item) begin
         high_ff      <= req_bar_high;
         low_ff       <= req_bar_low;
         mag_ff       <= req_mag;
         selling_ff   <= req_selling;
         delta_ff     <= DELTA_W'(signed'({1'b0, req_ask_volume}) -
                                  signed'({1'b0, req_bid_volume}));
         win_ff       <= eff_win;
         test_en_ff   <= bars_seen_ff >= eff_win;
         issue_cnt_ff <= '0;
         rd_ptr_ff    <= wr_ptr_dec;
         sum_ff       <= '0;
      end else begin
         if (issue_rd) begin
            issue_cnt_ff <= issue_cnt_ff + WIN_W'(1);
            rd_ptr_ff    <= rd_ptr_dec;
         end
         // shared accumulator walks back through the window
         if (rd_valid_ff) begin
            sum_ff <= sum_ff + SUM_W'(rd_data_ff);
         end
      end
      if (do_mul) begin
         lhs_ff <= {(SUM_W'(mag_ff) * SUM_W'(win_ff)), 4'b0000};
         rhs_ff <= RHS_W'(sum_ff) * RHS_W'(mult_ff);
      end
      if (load_rsp) begin
         fired_ff     <= fire;
         dir_ff       <= fire ? (selling_ff ? DIR_SELL : DIR_BUY) : DIR_NONE;
         marker_ff    <= fire ? marker_val : '0;
         rsp_delta_ff <= delta_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired        = fired_ff;
   assign rsp_direction    = dir_ff;
   assign rsp_marker_price = marker_ff;
   assign rsp_net_delta    = rsp_delta_ff;

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the windowed delta spike detector
`timescale 1ns / 1ps

module tb;
   import wdsd_pkg::*;

   // ring depth of the block under test (default parameter)
   localparam int unsigned RING_DEPTH = MAX_WINDOW_DEFAULT;
   localparam int unsigned FIELD_MAX = 24'hFFFFFF;
   // index with no register behind it, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1700;
   // longest latency is the largest window plus the fixed steps, with margin
   localparam int unsigned DRAIN_CYCLES = 160;
   localparam int unsigned MAX_REPORTS = 60;
   localparam longint TIMEOUT_NS = 10_000_000;

   typedef struct packed {
      logic [PRICE_W-1:0]  price_high;
      logic [PRICE_W-1:0]  price_low;
      logic [VOLUME_W-1:0] ask;
      logic [VOLUME_W-1:0] bid;
   } bar_type;

   typedef struct packed {
      logic                      fired;
      logic signed [DIR_W-1:0]   direction;
      logic [MARKER_W-1:0]       marker;
      logic signed [DELTA_W-1:0] delta;
   } spike_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [PRICE_W-1:0]          req_bar_high = '0;
   logic [PRICE_W-1:0]          req_bar_low = '0;
   logic [VOLUME_W-1:0]         req_ask_volume = '0;
   logic [VOLUME_W-1:0]         req_bid_volume = '0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_fired;
   logic signed [DIR_W-1:0]     rsp_direction;
   logic [MARKER_W-1:0]         rsp_marker_price;
   logic signed [DELTA_W-1:0]   rsp_net_delta;

   logic                        csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   // bars waiting to be sent, and spike results waiting to come back
   bar_type          pending_bars[$];
   spike_result_type expected_spikes[$];

   // register mirror, only changed while the block is idle
   logic [WIN_W-1:0]    cfg_window = WIN_RESET;
   logic [MULT_W-1:0]   cfg_mult_q4 = MULT_RESET;
   logic [OFFSET_W-1:0] cfg_offset = OFFSET_RESET;

   // own copy of the magnitude history
   logic [VOLUME_W-1:0] mag_history[RING_DEPTH];
   int unsigned         hist_ptr = 0;
   int unsigned         hist_count = 0;

   int unsigned error_count = 0;

   // sender burst/gap state and the transaction currently on the request port
   bar_type     driven_bar;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   // receiver stall pattern state
   int unsigned       stall_left = 0;
   logic              stall_now = 1'b0;
   spike_result_type  oldest_spike;

   windowed_delta_spike_detector i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_bar_high     (req_bar_high),
      .req_bar_low      (req_bar_low),
      .req_ask_volume   (req_ask_volume),
      .req_bid_volume   (req_bid_volume),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fired        (rsp_fired),
      .rsp_direction    (rsp_direction),
      .rsp_marker_price (rsp_marker_price),
      .rsp_net_delta    (rsp_net_delta),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // spike test for one bar, then push its magnitude into the history
   function automatic spike_result_type detect_spike(input bar_type bar);
      spike_result_type    res;
      logic                selling;
      logic [VOLUME_W-1:0] mag;
      int unsigned         w;
      int unsigned         pos;
      longint unsigned     sum;
      longint unsigned     lhs;
      longint unsigned     rhs;
      res = '0;
      res.direction = DIR_NONE;
      selling = bar.bid > bar.ask;
      mag = selling ? bar.bid - bar.ask : bar.ask - bar.bid;
      w = (int'(cfg_window) < RING_DEPTH) ? int'(cfg_window) : RING_DEPTH;
      res.delta = {1'b0, bar.ask} - {1'b0, bar.bid};
      // no signal during warm-up
      if (hist_count >= w) begin
         sum = 0;
         pos = hist_ptr;
         for (int k = 0; k < w; k++) begin
            pos = (pos == 0) ? RING_DEPTH - 1 : pos - 1;
            sum += 64'(mag_history[pos]);
         end
         // zero baseline never fires
         if (sum != 0) begin
            lhs = 64'(mag);
            lhs = lhs * w * 16;
            rhs = sum * 64'(cfg_mult_q4);
            if (lhs >= rhs) begin
               res.fired = 1'b1;
               if (selling) begin
                  res.direction = DIR_SELL;
                  // marker clamps at zero below the bar low
                  res.marker = (bar.price_low > PRICE_W'(cfg_offset))
                             ? MARKER_W'(bar.price_low - PRICE_W'(cfg_offset)) : '0;
               end else begin
                  // zero delta counts as buying
                  res.direction = DIR_BUY;
                  res.marker = {1'b0, bar.price_high} + MARKER_W'(cfg_offset);
               end
            end
         end
      end
      mag_history[hist_ptr] = mag;
      hist_ptr = (hist_ptr + 1 >= RING_DEPTH) ? 0 : hist_ptr + 1;
      if (hist_count < w) hist_count++;
      else hist_count = w;
      return res;
   endfunction

   function automatic bar_type make_bar(input int unsigned hi, input int unsigned lo,
                                        input int unsigned ask, input int unsigned bid);
      bar_type b;
      b.price_high = PRICE_W'(hi);
      b.price_low = PRICE_W'(lo);
      b.ask = VOLUME_W'(ask);
      b.bid = VOLUME_W'(bid);
      return b;
   endfunction

   // mostly quiet bars around a random level, some spikes, some pure noise
   function automatic bar_type random_bar();
      bar_type     b;
      int unsigned pick;
      int unsigned diff;
      int unsigned smaller;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         b = make_bar($urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX),
                      $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX));
      end else begin
         // low prices near zero exercise the marker clamp
         b.price_low = (pick < 22) ? PRICE_W'($urandom_range(0, 63))
                                   : PRICE_W'($urandom_range(0, FIELD_MAX - 500));
         b.price_high = b.price_low + PRICE_W'($urandom_range(0, 500));
         pick = $urandom_range(0, 99);
         diff = (pick < 3) ? 0 : (pick < 85) ? $urandom_range(0, 800)
                                             : $urandom_range(3000, 300000);
         smaller = $urandom_range(0, FIELD_MAX - diff);
         if ($urandom_range(0, 1) != 0) begin
            b.ask = VOLUME_W'(smaller + diff);
            b.bid = VOLUME_W'(smaller);
         end else begin
            b.ask = VOLUME_W'(smaller);
            b.bid = VOLUME_W'(smaller + diff);
         end
      end
      return b;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   // request driver: bursts of transactions with random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_spikes.push_back(detect_spike(driven_bar));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_bars.size() != 0) begin
               driven_bar = pending_bars.pop_front();
               req_bar_high <= driven_bar.price_high;
               req_bar_low <= driven_bar.price_low;
               req_ask_volume <= driven_bar.ask;
               req_bid_volume <= driven_bar.bid;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_spikes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual fired=%0b delta=%0h",
                     $time, rsp_fired, rsp_net_delta);
         end else begin
            oldest_spike = expected_spikes.pop_front();
            check_field("fired", 32'(oldest_spike.fired), 32'(rsp_fired));
            check_field("direction", 32'(oldest_spike.direction), 32'(rsp_direction));
            check_field("marker_price", 32'(oldest_spike.marker), 32'(rsp_marker_price));
            check_field("net_delta", 32'(oldest_spike.delta), 32'(rsp_net_delta));
         end
      end
      // stall runs, long free runs and short free runs
      if (stall_left != 0) begin
         stall_left--;
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               stall_now = 1'b1;
               stall_left = $urandom_range(1, 6);
            end
            1: begin
               stall_now = 1'b0;
               stall_left = $urandom_range(20, 80);
            end
            default: begin
               stall_now = 1'b0;
               stall_left = $urandom_range(1, 8);
            end
         endcase
      end
      rsp_stall <= stall_now;
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_WINDOW_LENGTH:  cfg_window = data[WIN_W-1:0];
         CSR_THRESHOLD_MULT: cfg_mult_q4 = data[MULT_W-1:0];
         CSR_MARKER_OFFSET:  cfg_offset = data[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   // block is idle once nothing is queued, in flight or outstanding
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_bars.size() != 0 || req_valid || expected_spikes.size() != 0);
   endtask

   initial begin
      int unsigned random_count;
      int unsigned phase;
      int unsigned win;
      int unsigned mult;
      int unsigned off;
      int unsigned phase_items;
      random_count = 0;
      phase = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: field extremes, all still in warm-up
      @(negedge clock);
      pending_bars.push_back(make_bar(0, 0, 0, 0));
      pending_bars.push_back(make_bar(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
      pending_bars.push_back(make_bar(FIELD_MAX, 0, FIELD_MAX, 0));
      pending_bars.push_back(make_bar(0, FIELD_MAX, 0, FIELD_MAX));
      wait_drained();

      // short window, unity multiplier, largest offset
      write_csr(CSR_WINDOW_LENGTH, 8'd5);
      write_csr(CSR_THRESHOLD_MULT, 8'd16);
      write_csr(CSR_MARKER_OFFSET, 8'd63);
      repeat (3) begin
         pending_bars.push_back(make_bar(1000, 900, 5100, 5000));
         pending_bars.push_back(make_bar(1000, 900, 5000, 5100));
      end
      void'(pending_bars.pop_back());
      // exactly at threshold, buying at top price: marker past 24 bits
      pending_bars.push_back(make_bar(FIELD_MAX, FIELD_MAX - 255, 700, 600));
      // selling spike with low below offset, then low equal to offset
      pending_bars.push_back(make_bar(50, 10, 0, FIELD_MAX));
      pending_bars.push_back(make_bar(200, 63, 0, FIELD_MAX));
      wait_drained();

      // zero multiplier fires on anything, zero delta counts as buying
      write_csr(CSR_THRESHOLD_MULT, 8'd0);
      write_csr(CSR_MARKER_OFFSET, 8'hC0);
      pending_bars.push_back(make_bar(777, 700, 12345, 12345));
      pending_bars.push_back(make_bar(40, 0, 1000, 1001));
      wait_drained();

      // zero window never fires; spare index must be ignored
      write_csr(CSR_WINDOW_LENGTH, 8'h80);
      write_csr(CSR_UNUSED, 8'hFF);
      pending_bars.push_back(make_bar(100, 90, FIELD_MAX, 0));
      pending_bars.push_back(make_bar(100, 90, 0, FIELD_MAX));
      wait_drained();

      // zero baseline: warm up on zero-delta bars, then a real delta
      write_csr(CSR_WINDOW_LENGTH, 8'd5);
      repeat (5) pending_bars.push_back(make_bar(300, 200, 4242, 4242));
      pending_bars.push_back(make_bar(300, 200, 5000, 4000));
      wait_drained();

      // random phases, each with its own settings, extremes at fixed phases
      while (random_count < RANDOM_ITEMS) begin
         win = (phase == 2) ? 127 : (phase == 6) ? 100 : (phase % 4 == 1) ? 5
                                                        : $urandom_range(1, 30);
         mult = (phase == 1) ? 255 : (phase == 4) ? 16 : (phase == 5) ? 160 :
                (phase == 8) ? 0 : $urandom_range(16, 160);
         off = (phase == 3) ? 63 : (phase == 7) ? 1 : $urandom_range(0, 63);
         // upper data bits set at random, the register must drop them
         write_csr(CSR_WINDOW_LENGTH, {1'($urandom_range(0, 1)), 7'(win)});
         write_csr(CSR_THRESHOLD_MULT, 8'(mult));
         write_csr(CSR_MARKER_OFFSET, {2'($urandom_range(0, 3)), 6'(off)});
         phase_items = win + $urandom_range(60, 160);
         repeat (phase_items) pending_bars.push_back(random_bar());
         random_count += phase_items;
         phase++;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/wdsd_pkg.sv
hdl/windowed_delta_spike_detector.sv
tb/tb.sv
